// ===== rtl/assert_macros.svh =====
// Assertion helpers; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, cond)

`define ASSERT_IMPLIES(label, pre, post)

`define ASSERT_NEXT(label, pre, post)

`endif

`endif

// ===== rtl/tmm_pkg.sv =====
package tmm_pkg;

    localparam int ID_W      = 8;
    localparam int KEY_W     = 3 * ID_W;
    localparam int MATCH_W   = 2 * ID_W;
    localparam int PAYLOAD_W = 64;
    localparam int SLOT_W    = 6;
    localparam int STATUS_W  = 2;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

// ===== rtl/tmm_table.sv =====
module tmm_table
    import tmm_pkg::*;
#(
    parameter int ENTRIES      = 64,
    parameter int PAYLOAD_BITS = 64,
    parameter int AW           = 6
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic                    wr_pay_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic [KEY_W-1:0]        wr_key,
    input  logic                    wr_flag,
    input  logic [PAYLOAD_BITS-1:0] wr_pay,
    input  logic                    rd_en,
    input  logic [AW-1:0]           rd_addr,
    output logic [KEY_W-1:0]        rd_key,
    output logic                    rd_flag,
    output logic [PAYLOAD_BITS-1:0] rd_pay
);

    // key memory entry: {read flag, sender, receiver, kind}
    logic [KEY_W:0]          key_mem [ENTRIES];
    logic [PAYLOAD_BITS-1:0] pay_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= {wr_flag, wr_key};
        end
        if (rd_en)
        begin
            {rd_flag, rd_key} <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_pay_en)
        begin
            pay_mem[wr_addr] <= wr_pay;
        end
        if (rd_en)
        begin
            rd_pay <= pay_mem[rd_addr];
        end
    end

endmodule

// ===== rtl/tagged_mailbox_match.sv =====
// Message mailbox with tag matching.
// An item is transferred in at a rising edge with start high and busy low.
// op = send stores sender, receiver, kind and payload in the next free slot;
// op = receive looks for the lowest-index unread entry whose receiver and
// kind equal the keys, marks it read and returns its slot, sender, payload.
// Every item yields exactly one result, shown for one cycle with done high;
// the receiver cannot stall it, so it must take the transfer that cycle.
// A send, or a receive on an empty table, gives its result the
// cycle after acceptance, and busy stays low, so such items may follow
// back to back. A receive walks the used slots one per cycle through the
// synchronous key memory and reports at the first hit or after the last
// used slot; busy is high meanwhile, so no new item is taken
// until the result is out. The flag write-back lands before the next item.
// Slots are never freed; once ENTRIES slots are used a send reports full.
// Reset clears the slot count and the control state; memory contents are
// left as they are and only written slots are ever read.
`include "assert_macros.svh"

module tagged_mailbox_match
    import tmm_pkg::*;
#(
    parameter int ENTRIES      = 64,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 op,
    input  logic [ID_W-1:0]      sender_id,
    input  logic [ID_W-1:0]      receiver_id,
    input  logic [ID_W-1:0]      message_kind,
    input  logic [PAYLOAD_W-1:0] payload_in,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [SLOT_W-1:0]    slot_index,
    output logic [ID_W-1:0]      sender_out,
    output logic [PAYLOAD_W-1:0] payload_out
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    state_t state_reg, state_next;

    logic [CW-1:0]        used_reg, used_next;
    logic [CW-1:0]        issue_reg, issue_next;
    logic [AW-1:0]        cmp_reg, cmp_next;
    logic [MATCH_W-1:0]   want_reg, want_next;
    logic                 done_reg, done_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [ID_W-1:0]      sender_reg, sender_next;
    logic [PAYLOAD_W-1:0] pay_reg, pay_next;

    logic                    wr_en, wr_pay_en, wr_flag, rd_en;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic [KEY_W-1:0]        wr_key, rd_key;
    logic                    rd_flag;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    logic                      accept, full, hit, more;
    logic                      slot_en;
    logic [AW-1:0]             slot_src;
    logic [AW+SLOT_W-1:0]      slot_wide;
    logic [PAYLOAD_BITS+PAYLOAD_W-1:0] pay_wide;

    tmm_table #(
        .ENTRIES      (ENTRIES),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .AW           (AW)
    ) u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_pay_en (wr_pay_en),
        .wr_addr   (wr_addr),
        .wr_key    (wr_key),
        .wr_flag   (wr_flag),
        .wr_pay    (payload_in[PAYLOAD_BITS-1:0]),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_key    (rd_key),
        .rd_flag   (rd_flag),
        .rd_pay    (rd_pay)
    );

    assign busy   = (state_reg == ST_SCAN);
    assign accept = start && !busy;
    assign full   = (used_reg == CW'(ENTRIES));
    assign more   = (issue_reg < used_reg);
    assign hit    = (state_reg == ST_SCAN) && !rd_flag
                    && (rd_key[MATCH_W-1:0] == want_reg);

    assign slot_wide = {{SLOT_W{1'b0}}, slot_src};
    assign pay_wide  = {{PAYLOAD_W{1'b0}}, rd_pay};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_RECV) && (used_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit || !more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        used_next   = used_reg;
        issue_next  = issue_reg;
        cmp_next    = cmp_reg;
        want_next   = want_reg;
        done_next   = 1'b0;
        status_next = STATUS_OK;
        sender_next = '0;
        pay_next    = '0;
        slot_en     = 1'b0;
        slot_src    = used_reg[AW-1:0];
        wr_en       = 1'b0;
        wr_pay_en   = 1'b0;
        wr_addr     = used_reg[AW-1:0];
        wr_key      = {sender_id, receiver_id, message_kind};
        wr_flag     = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    if (op == OP_SEND)
                    begin
                        if (full)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_pay_en = 1'b1;
                            used_next = used_reg + CW'(1);
                            slot_en   = 1'b1;
                        end
                    end
                    else
                    begin
                        want_next = {receiver_id, message_kind};
                        if (used_reg == '0)
                        begin
                            status_next = STATUS_NONE;
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            rd_en      = 1'b1;
                            cmp_next   = '0;
                            issue_next = CW'(1);
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    done_next   = 1'b1;
                    slot_en     = 1'b1;
                    slot_src    = cmp_reg;
                    sender_next = rd_key[KEY_W-1:MATCH_W];
                    pay_next    = pay_wide[PAYLOAD_W-1:0];
                    wr_en       = 1'b1;
                    wr_addr     = cmp_reg;
                    wr_key      = rd_key;
                    wr_flag     = 1'b1;
                end
                else if (more)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = issue_reg[AW-1:0];
                    cmp_next   = issue_reg[AW-1:0];
                    issue_next = issue_reg + CW'(1);
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_NONE;
                end
            end
            default:
            begin
            end
        endcase
        slot_next = slot_en ? slot_wide[SLOT_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            issue_reg <= '0;
            cmp_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            issue_reg <= issue_next;
            cmp_reg   <= cmp_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg   <= want_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        sender_reg <= sender_next;
        pay_reg    <= pay_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign slot_index  = slot_reg;
    assign sender_out  = sender_reg;
    assign payload_out = pay_reg;

    `ASSERT_ALWAYS(a_used_bound, used_reg <= CW'(ENTRIES))
    `ASSERT_IMPLIES(a_no_result_in_scan, busy, !done)
    `ASSERT_IMPLIES(a_scan_in_range, busy, (CW'(cmp_reg) < used_reg))
    `ASSERT_NEXT(a_empty_recv, accept && op == OP_RECV && used_reg == '0, done && status == STATUS_NONE)

endmodule
